[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the checker clock.
`define LWC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LWC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lwc_pkg.sv]
package lwc_pkg;
  // Coefficient fields are fixed at 32 bits; the divider sees |slope| as divisor.
  localparam int IN_W  = 32;
  localparam int DIV_W = 32;
  // Two divider lanes: bottom/top edges, or the vertical line on lane 0.
  localparam int LANES = 2;
endpackage

[hdl/line_window_clip.sv]
// Clips the line slope*x + B*y + offset = 0 (B = 0 when is_vertical, else -1) to the
// box spanned by two corners and returns one result beat per input beat, in order.
// A new line is taken every cycle while no result waits under out_stall_i. The
// bit-per-stage divider, on numerators of NW = max(COORD_BITS + FRAC_BITS, 32) + 1
// bits, solves the bottom and top edge crossings. The whole pipeline holds while a
// result waits under out_stall_i.
module line_window_clip import lwc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [IN_W-1:0]       slope_i,
  input  logic                         is_vertical_i,
  input  logic signed [IN_W-1:0]       offset_i,
  input  logic signed [COORD_BITS-1:0] corner_a_x_i,
  input  logic signed [COORD_BITS-1:0] corner_a_y_i,
  input  logic signed [COORD_BITS-1:0] corner_b_x_i,
  input  logic signed [COORD_BITS-1:0] corner_b_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         valid_res_o,
  output logic signed [COORD_BITS-1:0] start_x_o,
  output logic signed [COORD_BITS-1:0] start_y_o,
  output logic signed [COORD_BITS-1:0] end_x_o,
  output logic signed [COORD_BITS-1:0] end_y_o
);

  localparam int CB   = COORD_BITS;
  localparam int PW   = CB + IN_W;
  localparam int HW   = PW + 1;
  localparam int NW   = ((CB + FRAC_BITS > IN_W) ? CB + FRAC_BITS : IN_W) + 1;
  localparam int QW   = NW + 1;
  localparam int YW   = IN_W + 1;
  localparam int SATW = (HW > QW) ? HW : QW;

  localparam logic signed [HW-1:0]   RND_H = HW'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic signed [YW-1:0]   RND_Y = YW'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic signed [SATW-1:0] SMAX  = SATW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [SATW-1:0] SMIN  = SATW'(-(64'sd1 <<< (CB - 1)));

  typedef struct packed {
    logic                 a_zero;
    logic                 vert;
    logic signed [CB-1:0] mnx;
    logic signed [CB-1:0] mxx;
    logic signed [CB-1:0] mny;
    logic signed [CB-1:0] mxy;
    logic signed [HW-1:0] hy0;
    logic signed [HW-1:0] hy1;
    logic signed [YW-1:0] yh;
  } side_t;

  function automatic logic signed [CB-1:0] sat(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] r;
    r = v;
    if (v > SMAX) r = SMAX;
    if (v < SMIN) r = SMIN;
    return r[CB-1:0];
  endfunction

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: box bounds, edge products, divider numerators.
  logic signed [CB-1:0]   mnx_d, mxx_d, mny_d, mxy_d;
  logic signed [CB-1:0]   mnx_q, mxx_q, mny_q, mxy_q;
  logic signed [PW-1:0]   p0_d, p1_d, p0_q, p1_q;
  logic signed [NW-1:0]   n0_d, n1_d, n0_q, n1_q;
  logic signed [IN_W-1:0] a1_q, c1_q;
  logic                   vert1_q, az1_q, v1_q;

  always_comb begin
    mnx_d = (corner_a_x_i < corner_b_x_i) ? corner_a_x_i : corner_b_x_i;
    mxx_d = (corner_a_x_i < corner_b_x_i) ? corner_b_x_i : corner_a_x_i;
    mny_d = (corner_a_y_i < corner_b_y_i) ? corner_a_y_i : corner_b_y_i;
    mxy_d = (corner_a_y_i < corner_b_y_i) ? corner_b_y_i : corner_a_y_i;
    p0_d  = PW'(mnx_d) * PW'(slope_i);
    p1_d  = PW'(mxx_d) * PW'(slope_i);
    n0_d  = is_vertical_i ? -NW'(offset_i)
                          : (NW'(mny_d) <<< FRAC_BITS) - NW'(offset_i);
    n1_d  = (NW'(mxy_d) <<< FRAC_BITS) - NW'(offset_i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mnx_q   <= mnx_d;
      mxx_q   <= mxx_d;
      mny_q   <= mny_d;
      mxy_q   <= mxy_d;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      n0_q    <= n0_d;
      n1_q    <= n1_d;
      a1_q    <= slope_i;
      c1_q    <= offset_i;
      vert1_q <= is_vertical_i;
      az1_q   <= (slope_i == '0);
    end
  end

  // Stage 2: truncate edge y values, magnitudes for the divider.
  logic signed [HW-1:0]   s0, s1, t0, t1;
  logic signed [YW-1:0]   cy, ty;
  side_t                  side_d, side2_q;
  logic [LANES-1:0][NW-1:0]    mag_d, mag_q;
  logic [LANES-1:0][DIV_W-1:0] den_d, den_q;
  logic [LANES-1:0]            neg_d, neg_q;
  logic                        v2_q;

  always_comb begin
    s0 = HW'(c1_q) + HW'(p0_q);
    s1 = HW'(c1_q) + HW'(p1_q);
    t0 = s0 + (s0[HW-1] ? RND_H : HW'(0));
    t1 = s1 + (s1[HW-1] ? RND_H : HW'(0));
    cy = YW'(c1_q);
    ty = cy + (cy[YW-1] ? RND_Y : YW'(0));
    side_d.a_zero = az1_q;
    side_d.vert   = vert1_q;
    side_d.mnx    = mnx_q;
    side_d.mxx    = mxx_q;
    side_d.mny    = mny_q;
    side_d.mxy    = mxy_q;
    side_d.hy0    = t0 >>> FRAC_BITS;
    side_d.hy1    = t1 >>> FRAC_BITS;
    side_d.yh     = ty >>> FRAC_BITS;
    mag_d[0] = n0_q[NW-1] ? NW'(-n0_q) : NW'(n0_q);
    mag_d[1] = n1_q[NW-1] ? NW'(-n1_q) : NW'(n1_q);
    den_d[0] = a1_q[IN_W-1] ? DIV_W'(-a1_q) : DIV_W'(a1_q);
    den_d[1] = den_d[0];
    neg_d[0] = n0_q[NW-1] ^ a1_q[IN_W-1];
    neg_d[1] = n1_q[NW-1] ^ a1_q[IN_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side_d;
      mag_q   <= mag_d;
      den_q   <= den_d;
      neg_q   <= neg_d;
    end
  end

  // Divider stages.
  logic                   vd;
  logic [LANES-1:0][NW:0] quo;
  logic [$bits(side_t)-1:0] sd_raw;
  side_t                  sd;

  lwc_div #(.NW(NW), .SW($bits(side_t))) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .num_i   (mag_q),
    .den_i   (den_q),
    .neg_i   (neg_q),
    .side_i  (side2_q),
    .valid_o (vd),
    .quo_o   (quo),
    .side_o  (sd_raw)
  );
  assign sd = side_t'(sd_raw);

  // Stage 3: box tests and saturated hit points.
  logic signed [QW-1:0] q0, q1;
  logic [3:0]           keep_d, keep_q;
  logic signed [CB-1:0] hx_d [4];
  logic signed [CB-1:0] hy_d [4];
  logic signed [CB-1:0] hx_q [4];
  logic signed [CB-1:0] hy_q [4];
  logic signed [CB-1:0] yh_d, yh_q;
  logic                 az3_q, vert3_q, v3_q;

  always_comb begin
    q0 = signed'(quo[0]);
    q1 = signed'(quo[1]);
    keep_d[0] = (sd.hy0 >= HW'(sd.mny)) && (sd.hy0 <= HW'(sd.mxy));
    keep_d[1] = (sd.hy1 >= HW'(sd.mny)) && (sd.hy1 <= HW'(sd.mxy));
    keep_d[2] = (q0 >= QW'(sd.mnx)) && (q0 <= QW'(sd.mxx));
    keep_d[3] = (q1 >= QW'(sd.mnx)) && (q1 <= QW'(sd.mxx));
    hx_d[0] = sd.mnx;
    hy_d[0] = sat(SATW'(sd.hy0));
    hx_d[1] = sd.mxx;
    hy_d[1] = sat(SATW'(sd.hy1));
    hx_d[2] = sat(SATW'(q0));
    hy_d[2] = sd.mny;
    hx_d[3] = sat(SATW'(q1));
    hy_d[3] = sd.mxy;
    yh_d    = sat(SATW'(sd.yh));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      keep_q  <= keep_d;
      hx_q    <= hx_d;
      hy_q    <= hy_d;
      yh_q    <= yh_d;
      az3_q   <= sd.a_zero;
      vert3_q <= sd.vert;
    end
  end

  // Stage 4: pick endpoints.
  logic                 ok_d;
  logic signed [CB-1:0] sx_d, sy_d, ex_d, ey_d;
  logic                 have;
  logic [1:0]           fi;
  logic                 ok_q;
  logic signed [CB-1:0] sx_q, sy_q, ex_q, ey_q;

  always_comb begin
    have = 1'b0;
    fi   = '0;
    ok_d = 1'b0;
    sx_d = '0;
    sy_d = '0;
    ex_d = '0;
    ey_d = '0;
    for (int i = 0; i < 4; i++) begin
      if (keep_q[i] && !have) begin
        have = 1'b1;
        fi   = 2'(i);
      end
    end
    if (az3_q) begin
      if (!vert3_q) begin
        ok_d = 1'b1;
        sx_d = hx_q[0];
        sy_d = yh_q;
        ex_d = hx_q[1];
        ey_d = yh_q;
      end
    end else if (vert3_q) begin
      ok_d = 1'b1;
      sx_d = hx_q[2];
      sy_d = hy_q[2];
      ex_d = hx_q[2];
      ey_d = hy_q[3];
    end else begin
      sx_d = hx_q[fi];
      sy_d = hy_q[fi];
      // last kept hit after the first that differs from it
      for (int i = 1; i < 4; i++) begin
        if (keep_q[i] && (2'(i) > fi) && have &&
            ((hx_q[i] != hx_q[fi]) || (hy_q[i] != hy_q[fi]))) begin
          ok_d = 1'b1;
          ex_d = hx_q[i];
          ey_d = hy_q[i];
        end
      end
    end
    if (!ok_d) begin
      sx_d = '0;
      sy_d = '0;
      ex_d = '0;
      ey_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= ok_d;
      sx_q <= sx_d;
      sy_q <= sy_d;
      ex_q <= ex_d;
      ey_q <= ey_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= vd;
      out_valid_q <= v3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = ok_q;
  assign start_x_o   = sx_q;
  assign start_y_o   = sy_q;
  assign end_x_o     = ex_q;
  assign end_y_o     = ey_q;

endmodule

[hdl/lwc_div.sv]
module lwc_div import lwc_pkg::*; #(
  parameter int NW = 49,
  parameter int SW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [LANES-1:0][NW-1:0]      num_i,
  input  logic [LANES-1:0][DIV_W-1:0]   den_i,
  input  logic [LANES-1:0]              neg_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic [LANES-1:0][NW:0]        quo_o,
  output logic [SW-1:0]                 side_o
);

  logic [DIV_W-1:0] rem_q  [NW][LANES];
  logic [NW-1:0]    nq_q   [NW][LANES];
  logic [DIV_W-1:0] den_q  [NW][LANES];
  logic             neg_q  [NW][LANES];
  logic             v_q    [NW];
  logic [SW-1:0]    side_q [NW];

  // One quotient bit per stage, restoring.
  for (genvar k = 0; k < NW; k++) begin : g_stg
    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic [DIV_W-1:0] rp;
      logic [DIV_W-1:0] dp;
      logic [NW-1:0]    np;
      logic             ngp;
      logic [DIV_W:0]   trial;
      logic [DIV_W:0]   diff;
      logic             fit;

      if (k == 0) begin : g_first
        assign rp  = '0;
        assign np  = num_i[l];
        assign dp  = den_i[l];
        assign ngp = neg_i[l];
      end else begin : g_next
        assign rp  = rem_q[k-1][l];
        assign np  = nq_q[k-1][l];
        assign dp  = den_q[k-1][l];
        assign ngp = neg_q[k-1][l];
      end

      assign trial = {rp, np[NW-1]};
      assign diff  = trial - {1'b0, dp};
      assign fit   = trial >= {1'b0, dp};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= fit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
          nq_q[k][l]  <= {np[NW-2:0], fit};
          den_q[k][l] <= dp;
          neg_q[k][l] <= ngp;
        end
      end
    end

    logic          vp;
    logic [SW-1:0] sp;
    if (k == 0) begin : g_vfirst
      assign vp = valid_i;
      assign sp = side_i;
    end else begin : g_vnext
      assign vp = v_q[k-1];
      assign sp = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= sp;
      end
    end
  end

  // Apply the quotient sign.
  logic [LANES-1:0][NW:0] quo_q;
  logic                   ov_q;
  logic [SW-1:0]          so_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        quo_q[l] <= neg_q[NW-1][l] ? (NW+1)'(-{1'b0, nq_q[NW-1][l]})
                                   : {1'b0, nq_q[NW-1][l]};
      end
      so_q <= side_q[NW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_i) begin
      ov_q <= v_q[NW-1];
    end
  end

  assign valid_o = ov_q;
  assign quo_o   = quo_q;
  assign side_o  = so_q;

endmodule

[hdl/lwc_check.sv]
`include "assert_macros.svh"

module lwc_check import lwc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         valid_res_o,
  input logic signed [COORD_BITS-1:0] start_x_o,
  input logic signed [COORD_BITS-1:0] start_y_o,
  input logic signed [COORD_BITS-1:0] end_x_o,
  input logic signed [COORD_BITS-1:0] end_y_o
);

  // Input side holds exactly when a finished beat is held on the output.
  `LWC_ASSERT_IMP(a_stall_link, 1'b1, in_stall_o == (out_valid_o && out_stall_i), "stall mismatch")

  // A stalled result beat stays presented.
  `LWC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output beat dropped")

  // A rejected line reports zero endpoints.
  `LWC_ASSERT_IMP(a_invalid_zero, out_valid_o && !valid_res_o, (start_x_o == '0) && (start_y_o == '0) && (end_x_o == '0) && (end_y_o == '0), "invalid result not zeroed")

endmodule

bind line_window_clip lwc_check #(.COORD_BITS(COORD_BITS)) u_lwc_check (.*);

[verif/line_window_clip_tb.sv]
module line_window_clip_tb;
  import lwc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int LAT = 60;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic          ok;
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [CB-1:0] ex;
    logic [CB-1:0] ey;
  } clip_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic signed [IN_W-1:0] slope_i = 0;
  logic is_vertical_i = 0;
  logic signed [IN_W-1:0] offset_i = 0;
  logic signed [CB-1:0] corner_a_x_i = 0, corner_a_y_i = 0;
  logic signed [CB-1:0] corner_b_x_i = 0, corner_b_y_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic valid_res_o;
  logic signed [CB-1:0] start_x_o, start_y_o, end_x_o, end_y_o;

  clip_t segs_q[$];
  int errors = 0;
  longint cycles = 0;
  bit stall_en = 1;
  int stall_left = 0;

  line_window_clip #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (.*);

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [CB-1:0] sat(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    lo = -(longint'(1) <<< (CB - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CB-1:0];
  endfunction

  function automatic clip_t clip_line(longint a, bit vert, longint c,
                                      longint ax, longint ay, longint bx, longint by);
    longint mnx, mxx, mny, mxy, one, sx, sy, ex, ey;
    longint hx[4], hy[4], kx[4], ky[4];
    int n;
    bit ok, inb;
    clip_t r;
    mnx = ax < bx ? ax : bx; mxx = ax < bx ? bx : ax;
    mny = ay < by ? ay : by; mxy = ay < by ? by : ay;
    one = longint'(1) <<< FB;
    sx = 0; sy = 0; ex = 0; ey = 0; ok = 0; n = 0;
    if (a == 0) begin
      if (!vert) begin
        sy = c / one; ey = sy; sx = mnx; ex = mxx; ok = 1;
      end
    end else if (vert) begin
      sx = (-c) / a; ex = sx; sy = mny; ey = mxy; ok = 1;
    end else begin
      hx[0] = mnx; hy[0] = (c + mnx * a) / one;
      hx[1] = mxx; hy[1] = (c + mxx * a) / one;
      hy[2] = mny; hx[2] = (mny * one - c) / a;
      hy[3] = mxy; hx[3] = (mxy * one - c) / a;
      for (int i = 0; i < 4; i++) begin
        inb = (i < 2) ? (hy[i] >= mny && hy[i] <= mxy) : (hx[i] >= mnx && hx[i] <= mxx);
        if (inb) begin
          kx[n] = hx[i]; ky[n] = hy[i]; n++;
        end
      end
      if (n >= 2) begin
        sx = kx[0]; sy = ky[0];
        for (int i = 1; i < n; i++)
          if (kx[i] != sx || ky[i] != sy) begin
            ex = kx[i]; ey = ky[i]; ok = 1;
          end
      end
    end
    if (!ok) begin
      sx = 0; sy = 0; ex = 0; ey = 0;
    end
    r.ok = ok; r.sx = sat(sx); r.sy = sat(sy); r.ex = sat(ex); r.ey = sat(ey);
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_line(logic [31:0] a, bit v, logic [31:0] c,
                           logic [CB-1:0] ax, ay, bx, by, bit gaps = 1);
    int g;
    clip_t exp_seg;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1; slope_i <= a; is_vertical_i <= v; offset_i <= c;
    corner_a_x_i <= ax; corner_a_y_i <= ay; corner_b_x_i <= bx; corner_b_y_i <= by;
    do @(posedge clk_i); while (in_stall_o);
    exp_seg = clip_line(longint'($signed(a)), v, longint'($signed(c)),
      longint'($signed(ax)), longint'($signed(ay)),
      longint'($signed(bx)), longint'($signed(by)));
    segs_q = {segs_q, exp_seg};
  endtask

  // Hold the sender until every expected beat has drained.
  task automatic drain();
    in_valid_i <= 0;
    while (segs_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    clip_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{valid_res_o, start_x_o, start_y_o, end_x_o, end_y_o};
      if (segs_q.size() == 0) begin
        $display("%0t: unexpected beat exp none got %h", $realtime, got);
        errors++;
      end else begin
        want = segs_q.pop_front();
        if (got.ok !== want.ok)
          $display("%0t: valid_res exp %0d got %0d", $realtime, want.ok, got.ok);
        if (got.sx !== want.sx)
          $display("%0t: start_x exp %0d got %0d", $realtime, $signed(want.sx), $signed(got.sx));
        if (got.sy !== want.sy)
          $display("%0t: start_y exp %0d got %0d", $realtime, $signed(want.sy), $signed(got.sy));
        if (got.ex !== want.ex)
          $display("%0t: end_x exp %0d got %0d", $realtime, $signed(want.ex), $signed(got.ex));
        if (got.ey !== want.ey)
          $display("%0t: end_y exp %0d got %0d", $realtime, $signed(want.ey), $signed(got.ey));
        if (got !== want) errors++;
      end
    end
    // Mostly short output stalls, now and then a long one.
    if (!stall_en) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 29) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= int'($urandom_range(5, 40));
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i)
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end

  task automatic test_directed();
    send_line(0, 0, 32'h0003_8000, -10, -5, 20, 7);
    send_line(0, 0, 32'h8000_0000, 5, 5, -5, -5);
    send_line(0, 1, 32'h1234, 0, 0, 10, 10);
    send_line(32'h0001_0000, 1, 32'hFFFB_0000, 0, -3, 9, 4);
    send_line(32'h0000_0001, 1, 32'h7FFF_FFFF, 0, 0, 1, 1);
    send_line(32'h8000_0000, 1, 32'h8000_0000, 0, 0, 1, 1);
    send_line(32'h0001_0000, 0, 0, -10, -10, 10, 10);
    send_line(32'h0001_0000, 0, 0, 10, 10, -10, -10);
    send_line(32'hFFFF_0000, 0, 32'h0005_0000, -20, -20, 20, 20);
    send_line(32'h0001_0000, 0, 32'h0100_0000, 0, 0, 10, 10);
    send_line(32'h0001_0000, 0, 0, 3, 3, 3, 3);
    send_line(32'h0001_0000, 0, 0, 0, 0, 0, 0);
    send_line(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, -32768, -32768, 32767, 32767);
    send_line(32'h8000_0000, 0, 32'h8000_0000, -32768, -32768, 32767, 32767);
    send_line(32'h0000_0001, 0, 32'h7FFF_FFFF, -32768, -32768, 32767, 32767);
    send_line(32'h0100_0000, 0, 32'h7FFF_0000, -32768, 32767, 32767, -32768);
    send_line(32'h0002_0000, 0, 32'h0000_8000, -1, 0, 1, 1);
  endtask

  task automatic test_random();
    logic [31:0] a, c;
    logic [CB-1:0] ax, ay, bx, by;
    bit v;
    int k;
    for (int i = 0; i < 1800; i++) begin
      k = $urandom_range(0, 9);
      v = ($urandom_range(0, 5) == 0);
      a = $urandom; c = $urandom;
      ax = CB'($urandom); ay = CB'($urandom); bx = CB'($urandom); by = CB'($urandom);
      if (k < 6) begin
        // Keep the line near a modest box so that edge hits are common.
        ax = CB'($signed($urandom_range(0, 400)) - 200);
        bx = CB'($signed($urandom_range(0, 400)) - 200);
        ay = CB'($signed($urandom_range(0, 400)) - 200);
        by = CB'($signed($urandom_range(0, 400)) - 200);
        a = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        c = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      end else if (k == 6) a = 0;
      else if (k == 7) a = $signed($urandom_range(0, 6)) - 3;
      if (i == 900) drain();
      send_line(a, v, c, ax, ay, bx, by);
    end
  endtask

  task automatic test_back_to_back();
    stall_en = 0;
    for (int i = 0; i < 100; i++)
      send_line($urandom, 1'($urandom_range(0, 1)), $urandom, CB'($urandom),
                CB'($urandom), CB'($urandom), CB'($urandom), 0);
    stall_en = 1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_directed();
    test_back_to_back();
    test_random();
    drain();
    repeat (LAT * 2) @(posedge clk_i);
    if (errors == 0 && segs_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
